// ----- rtl/tkmm_pkg.sv -----
// Package for the two key motor mode controller: widths, register reset values,
// register indexes, mode and gear codes and the structs passed between modules.
// No dependencies; the RTL files use it by scoped names, the testbench by import.
package tkmm_pkg;

   // Hold counter width default and the depth of the queue between front and back.
   localparam int COUNT_WIDTH = 16;
   localparam int QUEUE_DEPTH = 2;

   // Port widths.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [15:0] LONG_PRESS_RST  = 16'd300;
   localparam logic [15:0] SHORT_PRESS_RST = 16'd10;
   localparam logic [31:0] STANDBY_LIM_RST = 32'd14400000;
   localparam logic [11:0] UNDERVOLT_RST   = 12'd2260;
   localparam logic [11:0] RECOVER_RST     = 12'd2684;
   localparam logic [7:0]  GEAR_ONE_RST    = 8'd150;
   localparam logic [7:0]  GEAR_TWO_RST    = 8'd175;
   localparam logic [6:0]  RAMP_UP_RST     = 7'd3;

   // Duty ramp constants, in tenths of a count except the idle duty and TENTHS.
   localparam logic [10:0] DUTY_MIN_T  = 11'd1000;
   localparam logic [10:0] DUTY_MAX_T  = 11'd2000;
   localparam logic [11:0] DUTY_IDLE_T = 12'd1000;
   localparam logic [10:0] RAMP_DOWN_T = 11'd10;
   localparam logic [7:0]  DUTY_IDLE   = 8'd100;
   localparam logic [11:0] TENTHS      = 12'd10;
   // floor(x / 10) equals (x * 6554) >> 16 for every x up to 2000.
   localparam logic [23:0] DIV10_MUL   = 24'd6554;

   // Register indexes, taken from paddr[4:2].
   typedef enum logic [2:0] {
      IDX_LONG_PRESS  = 3'd0,
      IDX_SHORT_PRESS = 3'd1,
      IDX_STANDBY_LIM = 3'd2,
      IDX_UNDERVOLT   = 3'd3,
      IDX_RECOVER     = 3'd4,
      IDX_GEAR_ONE    = 3'd5,
      IDX_GEAR_TWO    = 3'd6,
      IDX_RAMP_UP     = 3'd7
   } csr_index_type;

   // Run mode state, one-hot inside the block.
   typedef enum logic [2:0] {
      MODE_STOP    = 3'b001,
      MODE_STANDBY = 3'b010,
      MODE_ON      = 3'b100
   } mode_type;

   // Run mode codes as they appear in a result word.
   localparam logic [1:0] RUN_STOP    = 2'd0;
   localparam logic [1:0] RUN_STANDBY = 2'd1;
   localparam logic [1:0] RUN_ON      = 2'd2;

   typedef enum logic [1:0] {
      GEAR_OFF = 2'd0,
      GEAR_ONE = 2'd1,
      GEAR_TWO = 2'd2
   } gear_type;

   // Configuration as seen by the front and back.
   typedef struct packed {
      logic [15:0] long_press_ticks;
      logic [15:0] short_press_ticks;
      logic [31:0] standby_limit_ms;
      logic [11:0] undervolt_raw;
      logic [11:0] recover_raw;
      logic [7:0]  gear_one_duty;
      logic [7:0]  gear_two_duty;
      logic [6:0]  ramp_up_tenths;
   } cfg_type;

   // One classified control tick.
   typedef struct packed {
      logic        key_power_pressed;
      logic        key_speed_pressed;
      logic        supply_good;
      logic        supply_recover;
      logic [31:0] time_ms;
   } tick_type;

   // Head of the queue as offered to the back.
   typedef struct packed {
      logic     valid;
      tick_type tick;
   } queue_head_type;

endpackage

// ----- rtl/tkmm_csr.sv -----
// Configuration registers of the motor mode controller behind an APB-style port.
// Depends on tkmm_pkg.
module tkmm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tkmm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tkmm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tkmm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output tkmm_pkg::cfg_type                   cfg
);

   tkmm_pkg::cfg_type       cfg_ff;
   tkmm_pkg::cfg_type       cfg_in;
   tkmm_pkg::csr_index_type index;
   logic                    write_en;

   assign csr_pready = 1'b1;
   assign index      = tkmm_pkg::csr_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            tkmm_pkg::IDX_LONG_PRESS:  cfg_in.long_press_ticks  = csr_pwdata[15:0];
            tkmm_pkg::IDX_SHORT_PRESS: cfg_in.short_press_ticks = csr_pwdata[15:0];
            tkmm_pkg::IDX_STANDBY_LIM: cfg_in.standby_limit_ms  = csr_pwdata[31:0];
            tkmm_pkg::IDX_UNDERVOLT:   cfg_in.undervolt_raw     = csr_pwdata[11:0];
            tkmm_pkg::IDX_RECOVER:     cfg_in.recover_raw       = csr_pwdata[11:0];
            tkmm_pkg::IDX_GEAR_ONE:    cfg_in.gear_one_duty     = csr_pwdata[7:0];
            tkmm_pkg::IDX_GEAR_TWO:    cfg_in.gear_two_duty     = csr_pwdata[7:0];
            tkmm_pkg::IDX_RAMP_UP:     cfg_in.ramp_up_tenths    = csr_pwdata[6:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks  <= tkmm_pkg::LONG_PRESS_RST;
         cfg_ff.short_press_ticks <= tkmm_pkg::SHORT_PRESS_RST;
         cfg_ff.standby_limit_ms  <= tkmm_pkg::STANDBY_LIM_RST;
         cfg_ff.undervolt_raw     <= tkmm_pkg::UNDERVOLT_RST;
         cfg_ff.recover_raw       <= tkmm_pkg::RECOVER_RST;
         cfg_ff.gear_one_duty     <= tkmm_pkg::GEAR_ONE_RST;
         cfg_ff.gear_two_duty     <= tkmm_pkg::GEAR_TWO_RST;
         cfg_ff.ramp_up_tenths    <= tkmm_pkg::RAMP_UP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux, zero-extended to the bus width.
   always_comb begin
      csr_prdata = '0;
      unique case (index)
         tkmm_pkg::IDX_LONG_PRESS:  csr_prdata = 32'(cfg_ff.long_press_ticks);
         tkmm_pkg::IDX_SHORT_PRESS: csr_prdata = 32'(cfg_ff.short_press_ticks);
         tkmm_pkg::IDX_STANDBY_LIM: csr_prdata = cfg_ff.standby_limit_ms;
         tkmm_pkg::IDX_UNDERVOLT:   csr_prdata = 32'(cfg_ff.undervolt_raw);
         tkmm_pkg::IDX_RECOVER:     csr_prdata = 32'(cfg_ff.recover_raw);
         tkmm_pkg::IDX_GEAR_ONE:    csr_prdata = 32'(cfg_ff.gear_one_duty);
         tkmm_pkg::IDX_GEAR_TWO:    csr_prdata = 32'(cfg_ff.gear_two_duty);
         tkmm_pkg::IDX_RAMP_UP:     csr_prdata = 32'(cfg_ff.ramp_up_tenths);
      endcase
   end

endmodule

// ----- rtl/tkmm_front.sv -----
// Front of the motor mode controller: accepts input words, classifies keys and
// supply level, and holds them in a short queue for the back. Depends on tkmm_pkg.
module tkmm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  tkmm_pkg::cfg_type                   cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tkmm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output tkmm_pkg::queue_head_type            head,
   input  logic                                pop
);

   localparam int PTR_W = (tkmm_pkg::QUEUE_DEPTH > 1) ? $clog2(tkmm_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tkmm_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(tkmm_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(tkmm_pkg::QUEUE_DEPTH - 1);

   tkmm_pkg::tick_type  q_mem_ff [tkmm_pkg::QUEUE_DEPTH];
   tkmm_pkg::tick_type  tick;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [11:0]         sample;
   logic                push;

   // Classify the incoming word: active-low keys, supply against both thresholds.
   assign sample                 = req_tdata[13:2];
   assign tick.key_power_pressed = ~req_tdata[0];
   assign tick.key_speed_pressed = ~req_tdata[1];
   assign tick.supply_good       = (sample >= cfg.undervolt_raw);
   assign tick.supply_recover    = (sample >= cfg.recover_raw);
   assign tick.time_ms           = req_tdata[45:14];

   assign req_tready = (count_ff != DEPTH_C);
   assign push       = req_tvalid & req_tready;

   assign head.valid = (count_ff != '0);
   assign head.tick  = q_mem_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= tick;
      end
   end

endmodule

// ----- rtl/tkmm_back.sv -----
// Back of the motor mode controller: key hold tracking, mode and gear state,
// duty ramp, undervoltage lockout and the result register. Depends on tkmm_pkg.
module tkmm_back #(
   parameter int COUNT_WIDTH = tkmm_pkg::COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tkmm_pkg::cfg_type                   cfg,
   input  tkmm_pkg::queue_head_type            head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tkmm_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   // State registers.
   tkmm_pkg::mode_type     mode_ff, mode_in;
   tkmm_pkg::gear_type     gear_ff, gear_in;
   logic [COUNT_WIDTH-1:0] p_cnt_ff, p_cnt_in;
   logic [COUNT_WIDTH-1:0] s_cnt_ff, s_cnt_in;
   logic                   p_rel_ff, p_rel_in;
   logic                   s_rel_ff, s_rel_in;
   logic [31:0]            sstart_ff, sstart_in;
   logic [10:0]            ramp_ff, ramp_in;
   logic [7:0]             duty_ff, duty_in;
   logic                   lock_ff, lock_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [tkmm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Working values of one tick.
   tkmm_pkg::tick_type     tick;
   tkmm_pkg::mode_type     m;
   tkmm_pkg::gear_type     g;
   logic [COUNT_WIDTH-1:0] p_cnt, s_cnt;
   logic                   p_rel, s_rel;
   logic [31:0]            sstart;
   logic [7:0]             duty;
   logic                   lock;
   logic                   p_long, p_short, s_hit;
   logic [31:0]            elapsed;
   logic [11:0]            target_t;
   logic [11:0]            ramp_sum;
   logic [10:0]            ramp_new;
   logic [23:0]            div_prod;
   logic [1:0]             run_code;
   logic                   take;

   assign tick = head.tick;
   assign take = head.valid & (~rsp_valid_ff | rsp_tready);
   assign pop  = take;

   // One control tick, in the order the mode rules are applied.
   always_comb begin
      m      = mode_ff;
      g      = gear_ff;
      sstart = sstart_ff;
      duty   = duty_ff;
      lock   = lock_ff;

      // Key one hold counter and release flag.
      if (tick.key_power_pressed) begin
         p_cnt = (&p_cnt_ff) ? p_cnt_ff : p_cnt_ff + 1'b1;
         p_rel = p_rel_ff;
      end else begin
         p_cnt = '0;
         p_rel = 1'b1;
      end
      p_long  = (CMP_W'(p_cnt) >= CMP_W'(cfg.long_press_ticks));
      p_short = (CMP_W'(p_cnt) >= CMP_W'(cfg.short_press_ticks));

      // Long press arms standby from stop, or stops from standby.
      if (m == tkmm_pkg::MODE_STOP && p_long && p_rel) begin
         m      = tkmm_pkg::MODE_STANDBY;
         sstart = tick.time_ms;
         p_rel  = 1'b0;
         duty   = tkmm_pkg::DUTY_IDLE;
      end
      if (m == tkmm_pkg::MODE_STANDBY && p_long && p_rel) begin
         m     = tkmm_pkg::MODE_STOP;
         p_rel = 1'b0;
      end
      // Short press leaves the on state.
      if (m == tkmm_pkg::MODE_ON && p_rel && p_short) begin
         m     = tkmm_pkg::MODE_STANDBY;
         g     = tkmm_pkg::GEAR_OFF;
         p_rel = 1'b0;
      end
      // Standby timeout, counted from the last arming.
      elapsed = tick.time_ms - sstart;
      if (m == tkmm_pkg::MODE_STANDBY && elapsed >= cfg.standby_limit_ms) begin
         m = tkmm_pkg::MODE_STOP;
      end

      // Key two hold counter and release flag.
      if (tick.key_speed_pressed) begin
         s_cnt = (&s_cnt_ff) ? s_cnt_ff : s_cnt_ff + 1'b1;
         s_rel = s_rel_ff;
      end else begin
         s_cnt = '0;
         s_rel = 1'b1;
      end
      s_hit = (CMP_W'(s_cnt) >= CMP_W'(cfg.short_press_ticks)) && s_rel;

      // Gear selection.
      if (m == tkmm_pkg::MODE_STANDBY) begin
         if (s_hit) begin
            m     = tkmm_pkg::MODE_ON;
            g     = tkmm_pkg::GEAR_ONE;
            s_rel = 1'b0;
         end
      end else if (g == tkmm_pkg::GEAR_ONE) begin
         if (s_hit) begin
            m     = tkmm_pkg::MODE_ON;
            g     = tkmm_pkg::GEAR_TWO;
            s_rel = 1'b0;
         end
      end else if (g == tkmm_pkg::GEAR_TWO) begin
         if (s_hit) begin
            m     = tkmm_pkg::MODE_ON;
            g     = tkmm_pkg::GEAR_ONE;
            s_rel = 1'b0;
         end
      end

      // Target duty in tenths.
      target_t = tkmm_pkg::DUTY_IDLE_T;
      if (m == tkmm_pkg::MODE_ON) begin
         if (g == tkmm_pkg::GEAR_ONE) begin
            target_t = 12'(cfg.gear_one_duty) * tkmm_pkg::TENTHS;
         end else if (g == tkmm_pkg::GEAR_TWO) begin
            target_t = 12'(cfg.gear_two_duty) * tkmm_pkg::TENTHS;
         end
      end

      // Ramp step toward the target, then clamp.
      ramp_sum = 12'(ramp_ff);
      if (12'(ramp_ff) < target_t) begin
         ramp_sum = 12'(ramp_ff) + 12'(cfg.ramp_up_tenths);
      end else if (12'(ramp_ff) > target_t) begin
         ramp_sum = (ramp_ff >= tkmm_pkg::RAMP_DOWN_T) ?
                    12'(ramp_ff - tkmm_pkg::RAMP_DOWN_T) : '0;
      end
      priority if (ramp_sum < 12'(tkmm_pkg::DUTY_MIN_T)) begin
         ramp_new = tkmm_pkg::DUTY_MIN_T;
      end else if (ramp_sum > 12'(tkmm_pkg::DUTY_MAX_T)) begin
         ramp_new = tkmm_pkg::DUTY_MAX_T;
      end else begin
         ramp_new = ramp_sum[10:0];
      end
      div_prod = 24'(ramp_new) * tkmm_pkg::DIV10_MUL;

      // Undervoltage lockout with hysteresis.
      if (tick.supply_good) begin
         if (!lock) begin
            duty = div_prod[23:16];
         end
      end else begin
         m    = tkmm_pkg::MODE_STOP;
         g    = tkmm_pkg::GEAR_OFF;
         lock = 1'b1;
         duty = tkmm_pkg::DUTY_IDLE;
      end
      if (lock && tick.supply_recover) begin
         lock = 1'b0;
      end
   end

   // Mode code for the result word.
   always_comb begin
      run_code = tkmm_pkg::RUN_STOP;
      unique case (m)
         tkmm_pkg::MODE_STOP:    run_code = tkmm_pkg::RUN_STOP;
         tkmm_pkg::MODE_STANDBY: run_code = tkmm_pkg::RUN_STANDBY;
         tkmm_pkg::MODE_ON:      run_code = tkmm_pkg::RUN_ON;
         default:                run_code = tkmm_pkg::RUN_STOP;
      endcase
   end

   // Next state: only a taken tick moves the state; valid also drops on a read.
   always_comb begin
      mode_in     = take ? m : mode_ff;
      gear_in     = take ? g : gear_ff;
      p_cnt_in    = take ? p_cnt : p_cnt_ff;
      s_cnt_in    = take ? s_cnt : s_cnt_ff;
      p_rel_in    = take ? p_rel : p_rel_ff;
      s_rel_in    = take ? s_rel : s_rel_ff;
      sstart_in   = take ? sstart : sstart_ff;
      ramp_in     = take ? ramp_new : ramp_ff;
      duty_in     = take ? duty : duty_ff;
      lock_in     = take ? lock : lock_ff;
      rsp_data_in = take ?
                    {1'b0, lock, g, run_code, ((p_cnt != '0) | (s_cnt != '0)), duty,
                     (run_code != tkmm_pkg::RUN_STOP)} : rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= tkmm_pkg::MODE_STOP;
         gear_ff      <= tkmm_pkg::GEAR_OFF;
         p_cnt_ff     <= '0;
         s_cnt_ff     <= '0;
         p_rel_ff     <= 1'b0;
         s_rel_ff     <= 1'b0;
         sstart_ff    <= '0;
         ramp_ff      <= '0;
         duty_ff      <= '0;
         lock_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         gear_ff      <= gear_in;
         p_cnt_ff     <= p_cnt_in;
         s_cnt_ff     <= s_cnt_in;
         p_rel_ff     <= p_rel_in;
         s_rel_ff     <= s_rel_in;
         sstart_ff    <= sstart_in;
         ramp_ff      <= ramp_in;
         duty_ff      <= duty_in;
         lock_ff      <= lock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/two_key_motor_mode_controller_unit.sv -----
// Top level of the two key motor mode controller: configuration registers, front
// with its queue, and back with the result register. Depends on tkmm_pkg.
//
//   Group   Direction  Handshake               Contents
//   req_    in         tvalid/tready           one control tick word
//   rsp_    out        tvalid/tready           one status word per tick
//   csr_    in/out     psel/penable/pready     eight configuration registers
//
// One word is taken per cycle while the two-entry queue has room. The back takes it
// once its result register is free or being read, and registers its result word.
// The rate is set by the state update in the back.
// Synchronous active-high reset clears the state and leaves the queue empty.
// A stalled output fills the queue; the input stalls only when it is full.
module two_key_motor_mode_controller_unit #(
   parameter int COUNT_WIDTH = tkmm_pkg::COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] key_power_level, [1] key_speed_level, [13:2] supply_sample,
   // [45:14] time_ms, [47:46] zero
   input  logic [tkmm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] power_enable, [8:1] duty_count, [9] beep, [11:10] run_mode,
   // [13:12] gear_sel, [14] low_voltage, [15] zero
   output logic [tkmm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tkmm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tkmm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tkmm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   tkmm_pkg::cfg_type        cfg;
   tkmm_pkg::queue_head_type head;
   logic                     pop;

   tkmm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tkmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (head),
      .pop        (pop)
   );

   tkmm_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/tkmm_checker.sv -----
// Port-level checks for the two key motor mode controller, bound to the top level.
// Depends on tkmm_pkg and two_key_motor_mode_controller_unit.
module tkmm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [tkmm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tkmm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [tkmm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input logic [tkmm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input logic [tkmm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   input logic                                csr_pready
);

   // A stalled result word stays and holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Power switch follows the mode, and a gear is only selected while on.
   a_power_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[11:10] != tkmm_pkg::RUN_STOP)) &&
         (rsp_tdata[13:12] == tkmm_pkg::GEAR_OFF ||
          rsp_tdata[11:10] == tkmm_pkg::RUN_ON))
      else $error("power or gear inconsistent with mode");

   // The compare value stays within the duty clamp.
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:1] >= 8'd100 && rsp_tdata[8:1] <= 8'd200)
      else $error("duty count out of range");

endmodule

bind two_key_motor_mode_controller_unit tkmm_checker u_tkmm_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for two_key_motor_mode_controller_unit: predicts every status word
// from its own model of the key, ramp and lockout logic and checks it field by field.
// Depends on tkmm_pkg and the block's RTL only.
module tb_top;
   import tkmm_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 8;

   // Status word as laid out on rsp_tdata, lowest bit last.
   typedef struct packed {
      logic       pad;
      logic       low_voltage;
      logic [1:0] gear_sel;
      logic [1:0] run_mode;
      logic       beep;
      logic [7:0] duty_count;
      logic       power_enable;
   } status_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   // [0] key_power_level, [1] key_speed_level, [13:2] supply_sample, [45:14] time_ms
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [0] power_enable, [8:1] duty_count, [9] beep, [11:10] run_mode, [13:12] gear_sel,
   // [14] low_voltage
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Controller model state and its copy of the registers.
   cfg_type                cfg_now;
   logic [1:0]             mode_q;
   gear_type               gear_q;
   logic [COUNT_WIDTH-1:0] power_hold;
   logic [COUNT_WIDTH-1:0] speed_hold;
   bit                     power_free;
   bit                     speed_free;
   logic [31:0]            armed_ms;
   int unsigned            ramp_t;
   logic [7:0]             duty_q;
   bit                     lockout_q;

   status_word_type status_due[$];
   int           ticks_sent = 0;
   int           status_seen = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           hold_off_request = 0;
   int           hold_off_left = 0;
   logic [31:0]  now_ms = '0;

   two_key_motor_mode_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Run limit, in case the block hangs a handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_off_request != 0) begin
         hold_off_left = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input longint want_v,
                                  input longint got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s: expected %0d, got %0d at %0t", what, want_v, got_v,
                  $time);
   endtask

   // One control tick of the controller: updates the model state and returns the status word.
   function automatic status_word_type controller_tick(input logic [REQ_DATA_W-1:0] word);
      status_word_type s;
      logic         key_p;
      logic         key_s;
      logic [11:0]  sample;
      logic [31:0]  stamp;
      int unsigned  target_t;
      bit           hit;
      key_p  = word[0];
      key_s  = word[1];
      sample = word[13:2];
      stamp  = word[45:14];

      // Key one: saturating hold count, release noted on any high level.
      if (!key_p) begin
         if (power_hold != '1) power_hold = power_hold + 1'b1;
      end else begin
         power_hold = '0;
         power_free = 1'b1;
      end
      if (mode_q == RUN_STOP && power_hold >= cfg_now.long_press_ticks && power_free) begin
         mode_q     = RUN_STANDBY;
         armed_ms   = stamp;
         power_free = 1'b0;
         duty_q     = DUTY_IDLE;
      end
      if (mode_q == RUN_STANDBY && power_hold >= cfg_now.long_press_ticks && power_free) begin
         mode_q     = RUN_STOP;
         power_free = 1'b0;
      end
      if (mode_q == RUN_ON && power_free && power_hold >= cfg_now.short_press_ticks) begin
         mode_q     = RUN_STANDBY;
         gear_q     = GEAR_OFF;
         power_free = 1'b0;
      end
      // The standby timeout counts from the last arming, modulo 2^32.
      if (mode_q == RUN_STANDBY && (stamp - armed_ms) >= cfg_now.standby_limit_ms)
         mode_q = RUN_STOP;

      // Key two: leaves standby for gear one, then swaps gears.
      if (!key_s) begin
         if (speed_hold != '1) speed_hold = speed_hold + 1'b1;
      end else begin
         speed_hold = '0;
         speed_free = 1'b1;
      end
      hit = (speed_hold >= cfg_now.short_press_ticks) && speed_free;
      if (mode_q == RUN_STANDBY) begin
         if (hit) begin
            mode_q = RUN_ON;
            gear_q = GEAR_ONE;
            speed_free = 1'b0;
         end
      end else if (gear_q == GEAR_ONE) begin
         if (hit) begin
            mode_q = RUN_ON;
            gear_q = GEAR_TWO;
            speed_free = 1'b0;
         end
      end else if (gear_q == GEAR_TWO) begin
         if (hit) begin
            mode_q = RUN_ON;
            gear_q = GEAR_ONE;
            speed_free = 1'b0;
         end
      end

      // Duty ramp in tenths, clamped after each step.
      target_t = DUTY_IDLE * 10;
      if (mode_q == RUN_ON) begin
         if (gear_q == GEAR_ONE) target_t = cfg_now.gear_one_duty * 10;
         else if (gear_q == GEAR_TWO) target_t = cfg_now.gear_two_duty * 10;
      end
      if (ramp_t < target_t) ramp_t = ramp_t + cfg_now.ramp_up_tenths;
      else if (ramp_t > target_t) ramp_t = (ramp_t >= RAMP_DOWN_T) ? ramp_t - RAMP_DOWN_T : 0;
      if (ramp_t < DUTY_MIN_T) ramp_t = DUTY_MIN_T;
      if (ramp_t > DUTY_MAX_T) ramp_t = DUTY_MAX_T;

      // Undervoltage lockout with hysteresis; the compare value freezes while locked out.
      if (sample >= cfg_now.undervolt_raw) begin
         if (!lockout_q) duty_q = 8'(ramp_t / 10);
      end else begin
         mode_q    = RUN_STOP;
         gear_q    = GEAR_OFF;
         lockout_q = 1'b1;
         duty_q    = DUTY_IDLE;
      end
      if (lockout_q && sample >= cfg_now.recover_raw) lockout_q = 1'b0;

      s              = '0;
      s.power_enable = (mode_q != RUN_STOP);
      s.duty_count   = duty_q;
      s.beep         = (power_hold != '0) || (speed_hold != '0);
      s.run_mode     = mode_q;
      s.gear_sel     = gear_q;
      s.low_voltage  = lockout_q;
      return s;
   endfunction

   // Scoreboard: checks each status word, then records the prediction for each tick taken.
   always @(posedge clock) begin
      status_word_type got;
      status_word_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            status_seen++;
            got = rsp_tdata;
            if (status_due.size() == 0) begin
               report_mismatch("unexpected status word", 0, got);
            end else begin
               want = status_due.pop_front();
               if (got.power_enable !== want.power_enable)
                  report_mismatch("power_enable", want.power_enable, got.power_enable);
               if (got.duty_count !== want.duty_count)
                  report_mismatch("duty_count", want.duty_count, got.duty_count);
               if (got.beep !== want.beep)
                  report_mismatch("beep", want.beep, got.beep);
               if (got.run_mode !== want.run_mode)
                  report_mismatch("run_mode", want.run_mode, got.run_mode);
               if (got.gear_sel !== want.gear_sel)
                  report_mismatch("gear_sel", want.gear_sel, got.gear_sel);
               if (got.low_voltage !== want.low_voltage)
                  report_mismatch("low_voltage", want.low_voltage, got.low_voltage);
            end
         end
         if (req_tvalid && req_tready) status_due.push_back(controller_tick(req_tdata));
      end
   end

   // Offers one tick word, with random idle cycles ahead of it, and waits until it is taken.
   task automatic send_tick(input bit key_p, input bit key_s, input logic [11:0] sample,
                            input logic [31:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, stamp, sample, key_s, key_p};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   task automatic run_tick(input bit key_p, input bit key_s, input logic [11:0] sample,
                           input int advance);
      now_ms = now_ms + advance;
      send_tick(key_p, key_s, sample, now_ms);
   endtask

   // Stops offering words and waits until every outstanding status word has arrived.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (status_seen < ticks_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] register_value(input csr_index_type idx);
      case (idx)
         IDX_LONG_PRESS:  return {16'd0, cfg_now.long_press_ticks};
         IDX_SHORT_PRESS: return {16'd0, cfg_now.short_press_ticks};
         IDX_STANDBY_LIM: return cfg_now.standby_limit_ms;
         IDX_UNDERVOLT:   return {20'd0, cfg_now.undervolt_raw};
         IDX_RECOVER:     return {20'd0, cfg_now.recover_raw};
         IDX_GEAR_ONE:    return {24'd0, cfg_now.gear_one_duty};
         IDX_GEAR_TWO:    return {24'd0, cfg_now.gear_two_duty};
         default:         return {25'd0, cfg_now.ramp_up_tenths};
      endcase
   endfunction

   // Register read; prdata is taken in the access cycle and compared with the model copy.
   task automatic csr_read(input csr_index_type idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== register_value(idx))
         report_mismatch($sformatf("register %s", idx.name()), register_value(idx), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Register write once the block is idle, followed by a read back.
   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         IDX_LONG_PRESS:  cfg_now.long_press_ticks  = value[15:0];
         IDX_SHORT_PRESS: cfg_now.short_press_ticks = value[15:0];
         IDX_STANDBY_LIM: cfg_now.standby_limit_ms  = value;
         IDX_UNDERVOLT:   cfg_now.undervolt_raw     = value[11:0];
         IDX_RECOVER:     cfg_now.recover_raw       = value[11:0];
         IDX_GEAR_ONE:    cfg_now.gear_one_duty     = value[7:0];
         IDX_GEAR_TWO:    cfg_now.gear_two_duty     = value[7:0];
         default:         cfg_now.ramp_up_tenths    = value[6:0];
      endcase
      csr_read(idx);
   endtask

   task automatic apply_config(input int long_t, input int short_t, input logic [31:0] limit,
                               input int uv, input int rec, input int g1, input int g2,
                               input int up);
      csr_write(IDX_LONG_PRESS, long_t);
      csr_write(IDX_SHORT_PRESS, short_t);
      csr_write(IDX_STANDBY_LIM, limit);
      csr_write(IDX_UNDERVOLT, uv);
      csr_write(IDX_RECOVER, rec);
      csr_write(IDX_GEAR_ONE, g1);
      csr_write(IDX_GEAR_TWO, g2);
      csr_write(IDX_RAMP_UP, up);
   endtask

   // A supply sample that neither trips nor holds the lockout.
   function automatic logic [11:0] good_sample();
      int lo;
      lo = (cfg_now.undervolt_raw > cfg_now.recover_raw) ? cfg_now.undervolt_raw
                                                         : cfg_now.recover_raw;
      return 12'($urandom_range(4095, lo));
   endfunction

   function automatic int random_advance();
      if ($urandom_range(15) == 0) return $urandom_range(200);
      return $urandom_range(3);
   endfunction

   // One key or both held for a length around a threshold or at random, then released.
   task automatic random_gesture();
      int which;
      int hold;
      int gap;
      bit kp;
      bit ks;
      which = $urandom_range(2);
      case ($urandom_range(6))
         0: hold = int'(cfg_now.short_press_ticks) - 1;
         1: hold = int'(cfg_now.short_press_ticks);
         2: hold = int'(cfg_now.short_press_ticks) + 1;
         3: hold = int'(cfg_now.long_press_ticks) - 1;
         4: hold = int'(cfg_now.long_press_ticks);
         5: hold = int'(cfg_now.long_press_ticks) + 1;
         default: hold = $urandom_range(12);
      endcase
      if (hold > 40) hold = $urandom_range(40);
      kp = (which == 1);
      ks = (which == 0);
      for (int i = 0; i < hold; i++) run_tick(kp, ks, good_sample(), random_advance());
      gap = $urandom_range(1, 3);
      for (int i = 0; i < gap; i++) run_tick(1'b1, 1'b1, good_sample(), random_advance());
   endtask

   // A dip below the trip level, a stretch in the hysteresis band and a recovery.
   task automatic random_brownout();
      int n;
      if (cfg_now.undervolt_raw > 0) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++)
            run_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                     12'($urandom_range(int'(cfg_now.undervolt_raw) - 1)), random_advance());
      end
      if (cfg_now.recover_raw > cfg_now.undervolt_raw) begin
         n = $urandom_range(3);
         for (int i = 0; i < n; i++)
            run_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                     12'($urandom_range(int'(cfg_now.recover_raw) - 1,
                                        cfg_now.undervolt_raw)),
                     random_advance());
      end
      run_tick(1'b1, 1'b1, good_sample(), random_advance());
   endtask

   task automatic test_register_access();
      for (int i = 0; i < 8; i++) csr_read(csr_index_type'(i));
      apply_config(5, 2, 32'd40, 2260, 2684, 150, 175, 3);
   endtask

   // Arming, gear changes, leaving on, standby timeout across the wrap, lockout and recovery.
   task automatic test_directed_sequences();
      apply_config(3, 2, 32'd10, 1000, 3000, 150, 200, 100);
      now_ms = 32'hFFFF_FFF0;
      run_tick(1, 1, 12'hFFF, 0);
      repeat (3) run_tick(0, 1, 12'hFFF, 1);
      run_tick(1, 1, 12'd2000, 1);
      repeat (2) run_tick(1, 0, 12'hFFF, 1);
      run_tick(1, 1, 12'hFFF, 1);
      repeat (2) run_tick(1, 0, 12'hFFF, 1);
      repeat (2) run_tick(1, 1, 12'hFFF, 1);
      // A short press of key one drops to standby without renewing the arming time.
      repeat (2) run_tick(0, 1, 12'hFFF, 1);
      run_tick(1, 1, 12'hFFF, 5);
      now_ms = '0;
      send_tick(1, 1, 12'hFFF, now_ms);
      run_tick(1, 1, 12'd0, 1);
      run_tick(1, 1, 12'd2000, 1);
      run_tick(0, 0, 12'd2999, 1);
      run_tick(1, 1, 12'd3000, 1);
      run_tick(1, 1, 12'hFFF, 1);
      // Both keys together: arming and leaving standby on the same tick.
      repeat (3) run_tick(0, 0, 12'hFFF, 1);
      run_tick(1, 1, 12'hFFF, 1);
   endtask

   // Gear targets below and above the clamp range.
   task automatic test_target_out_of_range();
      apply_config(2, 1, 32'hFFFF_FFFF, 1000, 3000, 20, 255, 100);
      run_tick(1, 1, 12'hFFF, 1);
      repeat (2) run_tick(0, 1, 12'hFFF, 1);
      run_tick(1, 0, 12'hFFF, 1);
      repeat (3) run_tick(1, 1, 12'hFFF, 1);
      run_tick(1, 0, 12'hFFF, 1);
      repeat (11) run_tick(1, 1, 12'hFFF, 1);
   endtask

   // The receiver holds off while words come, so the input stalls; a full drain, then gestures.
   task automatic test_back_pressure();
      apply_config(4, 2, 32'd60, 2260, 2684, 150, 175, 3);
      hold_off_request = 300;
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(3) == 0) random_gesture();
         else run_tick(1, 1, good_sample(), 1);
      end
      wait_idle();
      for (int i = 0; i < 10; i++) random_gesture();
   endtask

   task automatic test_random_phase(input int n_items, input int idle_pct, input int stall_pct);
      int stop_at;
      int pick;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at = ticks_sent + n_items;
      while (ticks_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            random_gesture();
         end else if (pick < 87) begin
            random_brownout();
         end else begin
            now_ms = $urandom();
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                      12'($urandom_range(4095)), now_ms);
         end
      end
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // Long holds of both keys against the largest thresholds, which never fire.
   task automatic test_large_thresholds();
      apply_config(65535, 65535, 32'hFFFF_FFFF, 2260, 2684, 150, 175, 3);
      run_tick(1, 1, 12'hFFF, 1);
      repeat (40) run_tick(0, 0, 12'hFFF, 1);
      repeat (3) run_tick(1, 1, 12'hFFF, 1);
   endtask

   initial begin
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      // Model state after reset.
      cfg_now = '{LONG_PRESS_RST, SHORT_PRESS_RST, STANDBY_LIM_RST, UNDERVOLT_RST,
                  RECOVER_RST, GEAR_ONE_RST, GEAR_TWO_RST, RAMP_UP_RST};
      mode_q     = RUN_STOP;
      gear_q     = GEAR_OFF;
      power_hold = '0;
      speed_hold = '0;
      power_free = 1'b0;
      speed_free = 1'b0;
      armed_ms   = '0;
      ramp_t     = 0;
      duty_q     = '0;
      lockout_q  = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_directed_sequences();
      test_target_out_of_range();
      test_back_pressure();
      apply_config(6, 2, 32'd40, 2260, 2684, 150, 175, 3);
      test_random_phase(40, 0, 0);
      apply_config(1, 1, 32'd1, 0, 0, 100, 200, 1);
      test_random_phase(40, 50, 0);
      apply_config(65535, 65535, 32'hFFFF_FFFF, 4095, 4095, 200, 100, 100);
      test_random_phase(30, 0, 50);
      apply_config(8, 3, 32'd100, 1500, 3500, 190, 120, 37);
      test_random_phase(50, 21, 21);
      test_large_thresholds();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (status_due.size() != 0) begin
         report_mismatch("status words never delivered", 0, status_due.size());
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tkmm_pkg.sv
rtl/tkmm_csr.sv
rtl/tkmm_front.sv
rtl/tkmm_back.sv
rtl/two_key_motor_mode_controller_unit.sv
rtl/tkmm_checker.sv
dv/tb_top.sv
